// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define KDV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdv assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define KDV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdv assertion failed");

`endif

// ===== hw/rtl/kdv_pkg.sv =====
`default_nettype none

package kdv_pkg;

  localparam int unsigned DigitCount = 14;
  localparam logic [3:0] EmptyDigit = 4'd15;

  localparam logic [2:0] FieldNone   = 3'd0;
  localparam logic [2:0] FieldYear   = 3'd1;
  localparam logic [2:0] FieldMonth  = 3'd2;
  localparam logic [2:0] FieldDay    = 3'd3;
  localparam logic [2:0] FieldHour   = 3'd4;
  localparam logic [2:0] FieldMinute = 3'd5;
  localparam logic [2:0] FieldSecond = 3'd6;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_KEY    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    MSG_NONE       = 3'd0,
    MSG_SELECT     = 3'd1,
    MSG_INCOMPLETE = 3'd2,
    MSG_BAD_DATE   = 3'd3,
    MSG_BAD_TIME   = 3'd4,
    MSG_SAVING     = 3'd5
  } msg_e;

  typedef enum logic [1:0] {
    KEY_DIGIT,
    KEY_SAVE,
    KEY_BACK,
    KEY_NONE
  } key_kind_e;

  typedef logic [13:0][3:0] digits_t;

  // Input transaction after the load values have been split into digits.
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] field_select;
    logic [3:0] key_pos;
    digits_t    load_digits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status_message;
    logic        write_request;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  current_field;
    logic [55:0] digit_view;
  } out_item_t;

  // Verdict of the save check.
  typedef struct packed {
    logic        ok;
    msg_e        msg;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } save_res_t;

  function automatic key_kind_e key_kind(logic [3:0] key);
    case (key) inside
      [4'd0:4'd8], 4'd10: key_kind = KEY_DIGIT;
      4'd9:               key_kind = KEY_SAVE;
      4'd11:              key_kind = KEY_BACK;
      default:            key_kind = KEY_NONE;
    endcase
  endfunction

  // Keypad layout 7 8 9 / 4 5 6 / 1 2 3 / save 0 back.
  function automatic logic [3:0] key_digit(logic [3:0] key);
    case (key)
      4'd0:    key_digit = 4'd7;
      4'd1:    key_digit = 4'd8;
      4'd2:    key_digit = 4'd9;
      4'd3:    key_digit = 4'd4;
      4'd4:    key_digit = 4'd5;
      4'd5:    key_digit = 4'd6;
      4'd6:    key_digit = 4'd1;
      4'd7:    key_digit = 4'd2;
      4'd8:    key_digit = 4'd3;
      default: key_digit = 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] field_start(logic [2:0] field);
    case (field)
      FieldMonth:  field_start = 4'd4;
      FieldDay:    field_start = 4'd6;
      FieldHour:   field_start = 4'd8;
      FieldMinute: field_start = 4'd10;
      FieldSecond: field_start = 4'd12;
      default:     field_start = 4'd0;
    endcase
  endfunction

  function automatic logic [2:0] field_len(logic [2:0] field);
    case (field)
      FieldNone: field_len = 3'd0;
      FieldYear: field_len = 3'd4;
      default:   field_len = 3'd2;
    endcase
  endfunction

  function automatic logic [4:0] month_limit(logic [3:0] month, logic leap);
    case (month) inside
      4'd2:                     month_limit = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  month_limit = 5'd30;
      default:                  month_limit = 5'd31;
    endcase
  endfunction

  // Split a 7-bit value into tens and units; tens stays unreduced (up to 12).
  // v / 10 == (v * 103) >> 10 for every v below 170.
  function automatic logic [7:0] split_two(logic [6:0] v);
    logic [16:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {10'd0, v} * 17'd103;
    tens  = prod[13:10];
    units = v - 7'({3'd0, tens} * 7'd10);
    split_two = {tens, units[3:0]};
  endfunction

  // Split a 14-bit year into four decimal digits, each modulo 10.
  // Reciprocals are exact over the whole 14-bit range.
  function automatic logic [15:0] split_year(logic [13:0] y);
    logic [28:0] p10;
    logic [28:0] p100;
    logic [28:0] p1000;
    logic [10:0] q10;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [13:0] r1;
    logic [10:0] r10;
    logic [7:0]  r100;
    logic [4:0]  r1000;
    p10   = {15'd0, y} * 29'd13108;
    p100  = {15'd0, y} * 29'd5243;
    p1000 = {15'd0, y} * 29'd16778;
    q10   = p10[27:17];
    q100  = p100[26:19];
    q1000 = p1000[28:24];
    r1    = y - 14'({3'd0, q10} * 14'd10);
    r10   = q10 - 11'({3'd0, q100} * 11'd10);
    r100  = q100 - 8'({3'd0, q1000} * 8'd10);
    r1000 = (q1000 >= 5'd10) ? q1000 - 5'd10 : q1000;
    split_year = {r1000[3:0], r100[3:0], r10[3:0], r1[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kdv_intf.sv =====
`default_nettype none

interface kdv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  field_select;
  logic [3:0]  key_pos;
  logic [13:0] load_year;
  logic [6:0]  load_month;
  logic [6:0]  load_day;
  logic [6:0]  load_hour;
  logic [6:0]  load_minute;
  logic [6:0]  load_second;

  modport source (
    output valid, action, field_select, key_pos, load_year, load_month,
           load_day, load_hour, load_minute, load_second,
    input  ready
  );
  modport sink (
    input  valid, action, field_select, key_pos, load_year, load_month,
           load_day, load_hour, load_minute, load_second,
    output ready
  );
endinterface

interface kdv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_message;
  logic        write_request;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  current_field;
  logic [55:0] digit_view;

  modport source (
    output valid, status_message, write_request, out_year, out_month, out_day,
           out_hour, out_minute, out_second, current_field, digit_view,
    input  ready
  );
  modport sink (
    input  valid, status_message, write_request, out_year, out_month, out_day,
           out_hour, out_minute, out_second, current_field, digit_view,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/kdv_save_check.sv =====
`default_nettype none

module kdv_save_check (
  input  var kdv_pkg::digits_t   digits_i,
  output kdv_pkg::save_res_t     res_o
);

  logic        any_empty;
  logic [14:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  logic        leap;
  logic        date_ok;
  logic        time_ok;

  function automatic logic [7:0] two_digits(logic [3:0] hi, logic [3:0] lo);
    two_digits = ({4'd0, hi} * 8'd10) + {4'd0, lo};
  endfunction

  always_comb begin
    any_empty = 1'b0;
    for (int i = 0; i < kdv_pkg::DigitCount; i++) begin
      if (digits_i[i] == kdv_pkg::EmptyDigit) begin
        any_empty = 1'b1;
      end
    end
  end

  assign year = ({11'd0, digits_i[0]} * 15'd1000) + ({11'd0, digits_i[1]} * 15'd100)
              + ({11'd0, digits_i[2]} * 15'd10) + {11'd0, digits_i[3]};
  assign month  = two_digits(digits_i[4], digits_i[5]);
  assign day    = two_digits(digits_i[6], digits_i[7]);
  assign hour   = two_digits(digits_i[8], digits_i[9]);
  assign minute = two_digits(digits_i[10], digits_i[11]);
  assign second = two_digits(digits_i[12], digits_i[13]);

  // Within 2000..2099 the century rule only touches 2000, itself a leap year.
  assign leap = (year[1:0] == 2'b00);

  assign date_ok = (year >= 15'd2000) && (year <= 15'd2099)
                && (month >= 8'd1) && (month <= 8'd12) && (day >= 8'd1)
                && (day <= {3'd0, kdv_pkg::month_limit(month[3:0], leap)});
  assign time_ok = (hour <= 8'd23) && (minute <= 8'd59) && (second <= 8'd59);

  always_comb begin
    res_o = '0;
    if (any_empty) begin
      res_o.msg = kdv_pkg::MSG_INCOMPLETE;
    end else if (!date_ok) begin
      res_o.msg = kdv_pkg::MSG_BAD_DATE;
    end else if (!time_ok) begin
      res_o.msg = kdv_pkg::MSG_BAD_TIME;
    end else begin
      res_o.ok     = 1'b1;
      res_o.msg    = kdv_pkg::MSG_SAVING;
      res_o.year   = year[11:0];
      res_o.month  = month[3:0];
      res_o.day    = day[4:0];
      res_o.hour   = hour[4:0];
      res_o.minute = minute[5:0];
      res_o.second = second[5:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_datetime_entry_validator_core.sv =====
// Keypad date/time entry validator.
// Input channel in_i (sink): one transaction is an action - load a clock reading
// into the 14-digit YYYYMMDDhhmmss buffer, select a field, or press a keypad key
// (digit, backspace or save). Output channel out_o (source): exactly one result
// transaction per input transaction, in order, carrying the status message,
// the write request with validated values on a good save, the selected field
// and the whole digit buffer after the edit.
// A transaction accepted into the input register is processed into the result
// register and offered on out_o from then on. Throughput: one transaction per
// cycle while out_o.ready is high; the edit and save check are one short pass
// between the input and result registers, so the state update sets the rate.
// The load values are split into decimal digits as they enter the input
// register, so the constant multipliers sit ahead of the editing logic.
// Stall: while out_o.valid is high and out_o.ready low the result register holds;
// an empty input register still takes one more transaction, then in_i.ready drops.
// Reset (rst_ni low, asynchronous): every digit becomes empty (15), no field is
// selected, the message is none and both pipeline registers are emptied.
`default_nettype none

module keypad_datetime_entry_validator_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  kdv_in_if.sink           in_i,
  kdv_out_if.source        out_o
);

  // Input stage
  logic               in_valid_q;
  kdv_pkg::in_item_t  in_q;
  kdv_pkg::in_item_t  in_d;
  logic               fire;

  // Editing state
  kdv_pkg::digits_t   digits_q, digits_d;
  logic [2:0]         sel_q, sel_d;
  logic [1:0]         off_q, off_d;
  logic               started_q, started_d;
  kdv_pkg::msg_e      msg_q, msg_d;

  // Result stage
  logic               out_valid_q;
  kdv_pkg::out_item_t out_q, out_d;

  kdv_pkg::save_res_t save_res;
  logic               wr;
  logic [3:0]         fstart;
  logic [2:0]         flen;
  logic [1:0]         off_eff;
  logic [1:0]         off_next;
  logic [3:0]         pos;
  logic [55:0]        view;

  // Split the load values into digits as the transaction enters.
  always_comb begin
    logic [15:0] ysplit;
    logic [7:0]  pair;
    in_d.action       = in_i.action;
    in_d.field_select = in_i.field_select;
    in_d.key_pos      = in_i.key_pos;
    ysplit = kdv_pkg::split_year(in_i.load_year);
    in_d.load_digits[0] = ysplit[15:12];
    in_d.load_digits[1] = ysplit[11:8];
    in_d.load_digits[2] = ysplit[7:4];
    in_d.load_digits[3] = ysplit[3:0];
    pair = kdv_pkg::split_two(in_i.load_month);
    in_d.load_digits[4]  = pair[7:4];
    in_d.load_digits[5]  = pair[3:0];
    pair = kdv_pkg::split_two(in_i.load_day);
    in_d.load_digits[6]  = pair[7:4];
    in_d.load_digits[7]  = pair[3:0];
    pair = kdv_pkg::split_two(in_i.load_hour);
    in_d.load_digits[8]  = pair[7:4];
    in_d.load_digits[9]  = pair[3:0];
    pair = kdv_pkg::split_two(in_i.load_minute);
    in_d.load_digits[10] = pair[7:4];
    in_d.load_digits[11] = pair[3:0];
    pair = kdv_pkg::split_two(in_i.load_second);
    in_d.load_digits[12] = pair[7:4];
    in_d.load_digits[13] = pair[3:0];
  end

  // Advance when the result register is free or being drained.
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_d;
    end
  end

  kdv_save_check u_save_check (
    .digits_i (digits_q),
    .res_o    (save_res)
  );

  assign fstart   = kdv_pkg::field_start(sel_q);
  assign flen     = kdv_pkg::field_len(sel_q);
  // A fresh entry starts at the left of the field.
  assign off_eff  = started_q ? off_q : 2'd0;
  assign off_next = off_eff + 2'd1;
  assign pos      = fstart + {2'd0, off_eff};

  always_comb begin
    digits_d  = digits_q;
    sel_d     = sel_q;
    off_d     = off_q;
    started_d = started_q;
    msg_d     = msg_q;
    wr        = 1'b0;
    case (kdv_pkg::action_e'(in_q.action))
      kdv_pkg::ACT_LOAD: begin
        digits_d = in_q.load_digits;
        msg_d    = kdv_pkg::MSG_NONE;
      end
      kdv_pkg::ACT_SELECT: begin
        sel_d     = (in_q.field_select <= kdv_pkg::FieldSecond) ? in_q.field_select
                                                                : kdv_pkg::FieldNone;
        off_d     = 2'd0;
        started_d = 1'b0;
        msg_d     = kdv_pkg::MSG_NONE;
      end
      kdv_pkg::ACT_KEY: begin
        case (kdv_pkg::key_kind(in_q.key_pos))
          kdv_pkg::KEY_SAVE: begin
            msg_d = save_res.msg;
            wr    = save_res.ok;
          end
          kdv_pkg::KEY_BACK: begin
            if (sel_q == kdv_pkg::FieldNone) begin
              msg_d = kdv_pkg::MSG_SELECT;
            end else begin
              for (int i = 0; i < kdv_pkg::DigitCount; i++) begin
                if ((4'(i) >= fstart) && (4'(i) < fstart + {1'b0, flen})) begin
                  digits_d[i] = kdv_pkg::EmptyDigit;
                end
              end
              off_d     = 2'd0;
              started_d = 1'b1;
              msg_d     = kdv_pkg::MSG_NONE;
            end
          end
          kdv_pkg::KEY_DIGIT: begin
            if (sel_q == kdv_pkg::FieldNone) begin
              msg_d = kdv_pkg::MSG_SELECT;
            end else begin
              // First digit of an entry blanks the whole field.
              if (!started_q) begin
                for (int i = 0; i < kdv_pkg::DigitCount; i++) begin
                  if ((4'(i) >= fstart) && (4'(i) < fstart + {1'b0, flen})) begin
                    digits_d[i] = kdv_pkg::EmptyDigit;
                  end
                end
              end
              digits_d[pos] = kdv_pkg::key_digit(in_q.key_pos);
              msg_d         = kdv_pkg::MSG_NONE;
              if ((off_next == 2'd0) || ({1'b0, off_next} >= flen)) begin
                // Field full: move on, dropping the selection after seconds.
                sel_d     = (sel_q == kdv_pkg::FieldSecond) ? kdv_pkg::FieldNone
                                                            : sel_q + 3'd1;
                off_d     = 2'd0;
                started_d = 1'b0;
              end else begin
                off_d     = off_next;
                started_d = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < kdv_pkg::DigitCount; i++) begin
      view[55 - 4 * i -: 4] = digits_d[i];
    end
  end

  always_comb begin
    out_d                = '0;
    out_d.status_message = msg_d;
    out_d.write_request  = wr;
    out_d.current_field  = sel_d;
    out_d.digit_view     = view;
    if (wr) begin
      out_d.out_year   = save_res.year;
      out_d.out_month  = save_res.month;
      out_d.out_day    = save_res.day;
      out_d.out_hour   = save_res.hour;
      out_d.out_minute = save_res.minute;
      out_d.out_second = save_res.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q    <= {kdv_pkg::DigitCount{kdv_pkg::EmptyDigit}};
      sel_q       <= kdv_pkg::FieldNone;
      off_q       <= 2'd0;
      started_q   <= 1'b0;
      msg_q       <= kdv_pkg::MSG_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        digits_q    <= digits_d;
        sel_q       <= sel_d;
        off_q       <= off_d;
        started_q   <= started_d;
        msg_q       <= msg_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset: valid guards it.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status_message = out_q.status_message;
  assign out_o.write_request  = out_q.write_request;
  assign out_o.out_year       = out_q.out_year;
  assign out_o.out_month      = out_q.out_month;
  assign out_o.out_day        = out_q.out_day;
  assign out_o.out_hour       = out_q.out_hour;
  assign out_o.out_minute     = out_q.out_minute;
  assign out_o.out_second     = out_q.out_second;
  assign out_o.current_field  = out_q.current_field;
  assign out_o.digit_view     = out_q.digit_view;

endmodule

`default_nettype wire

// ===== hw/rtl/kdv_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module kdv_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [2:0]  status_message_i,
  input wire        write_request_i,
  input wire [11:0] out_year_i,
  input wire [3:0]  out_month_i,
  input wire [4:0]  out_day_i,
  input wire [4:0]  out_hour_i,
  input wire [5:0]  out_minute_i,
  input wire [5:0]  out_second_i,
  input wire [2:0]  current_field_i,
  input wire [55:0] digit_view_i
);

  // A stalled result stays valid and holds its digit view and message.
  `KDV_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(digit_view_i) && $stable(status_message_i))

  // A write request only comes with the saving message.
  `KDV_ASSERT_IMP(a_write_saving, clk_i, rst_ni, out_valid_i && write_request_i, status_message_i == kdv_pkg::MSG_SAVING)

  // Without a write request every date and time output is zero.
  `KDV_ASSERT_IMP(a_no_write_zero, clk_i, rst_ni, out_valid_i && !write_request_i, out_year_i == 12'd0 && out_month_i == 4'd0 && out_day_i == 5'd0 && out_hour_i == 5'd0 && out_minute_i == 6'd0 && out_second_i == 6'd0)

  // Written values lie in range; the day is checked only against its lower bound.
  `KDV_ASSERT_IMP(a_write_range, clk_i, rst_ni, out_valid_i && write_request_i, out_year_i >= 12'd2000 && out_year_i <= 12'd2099 && out_month_i >= 4'd1 && out_month_i <= 4'd12 && out_day_i >= 5'd1 && out_hour_i <= 5'd23 && out_minute_i <= 6'd59 && out_second_i <= 6'd59 && current_field_i != 3'd7)

endmodule

bind keypad_datetime_entry_validator_core kdv_checker u_kdv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_message_i (out_o.status_message),
  .write_request_i  (out_o.write_request),
  .out_year_i       (out_o.out_year),
  .out_month_i      (out_o.out_month),
  .out_day_i        (out_o.out_day),
  .out_hour_i       (out_o.out_hour),
  .out_minute_i     (out_o.out_minute),
  .out_second_i     (out_o.out_second),
  .current_field_i  (out_o.current_field),
  .digit_view_i     (out_o.digit_view)
);

`default_nettype wire
